### rtl/psc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pkg
// shared types and constants of the pressure sensor compensation pipeline
// ----------------------------------------------------------------------------
package psc_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_SENS          = 3'd0,
		CFG_OFFSET        = 3'd1,
		CFG_SENS_TEMPCO   = 3'd2,
		CFG_OFFSET_TEMPCO = 3'd3,
		CFG_REF_TEMP      = 3'd4,
		CFG_TEMP_SLOPE    = 3'd5
	} cfg_idx_t;

	localparam int unsigned RAW_W  = 24;
	localparam int unsigned COEF_W = 16;
	localparam int unsigned TEMP_W = 19;
	localparam int unsigned PRES_W = 32;

	// reference temperature 20.00 degC and the very low range edge -15.00 degC
	localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
	localparam logic signed [19:0] VLOW_BIAS = 20'sd3500;
	localparam logic signed [18:0] VLOW_DEV  = -19'sd3500;

	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sh3ffff;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = 19'sh40000;
	localparam logic signed [PRES_W-1:0] PRES_MAX = 32'sh7fffffff;
	localparam logic signed [PRES_W-1:0] PRES_MIN = 32'sh80000000;

	typedef struct packed {
		logic [COEF_W-1:0] sens;
		logic [COEF_W-1:0] offset;
		logic [COEF_W-1:0] sens_tempco;
		logic [COEF_W-1:0] offset_tempco;
		logic [COEF_W-1:0] ref_temp;
		logic [COEF_W-1:0] temp_slope;
	} coef_t;

	// first order results
	typedef struct packed {
		logic [RAW_W-1:0]  d1;
		logic signed [18:0] q;     // temp - 2000
		logic signed [35:0] off;
		logic signed [35:0] sens;
		logic [17:0]       ti;
	} fo_t;

	// second order results
	typedef struct packed {
		logic [RAW_W-1:0]        d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [40:0]      sd;   // sens - sensi
		logic signed [41:0]      od;   // off - offi
	} so_t;

endpackage
`default_nettype wire

### rtl/psc_first_order.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_first_order
// dT, first order temperature, offset and sensitivity, Ti term (three stages)
// ----------------------------------------------------------------------------
module psc_first_order (
	input  logic               clk,
	input  logic               arst_n,
	input  psc_pkg::coef_t     coef,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [23:0]        pressure_raw,
	input  logic [23:0]        temperature_raw,
	output logic               out_valid,
	input  logic               out_ready,
	output psc_pkg::fo_t       out_data
);
	import psc_pkg::*;

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic [23:0]        d1_s1, d1_s2;
	logic signed [24:0] dt_s1;
	logic signed [41:0] p6_s2, p4_s2, p3_s2;
	logic signed [49:0] dsq_s2;
	fo_t                fo_s3;

	logic signed [41:0] p6_adj, p4_adj, p3_adj;
	logic signed [18:0] q_c;
	logic [50:0]        dsq3;
	logic [17:0]        ti_lo, ti_hi;
	fo_t                fo_c;

	assign rdy_s1   = ~vld_s1 | rdy_s2;
	assign rdy_s2   = ~vld_s2 | rdy_s3;
	assign rdy_s3   = ~vld_s3 | out_ready;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	// truncating divides: add divisor-1 to negative values before the shift
	assign p6_adj = p6_s2 + (p6_s2[41] ? 42'sd8388607 : 42'sd0);
	assign p4_adj = p4_s2 + (p4_s2[41] ? 42'sd127 : 42'sd0);
	assign p3_adj = p3_s2 + (p3_s2[41] ? 42'sd255 : 42'sd0);
	assign q_c    = $signed(p6_adj[41:23]);

	// dT^2 is never negative, so plain shifts give the floor
	assign dsq3  = {2'b00, dsq_s2[48:0]} + {1'b0, dsq_s2[48:0], 1'b0};
	assign ti_lo = dsq3[50:33];
	assign ti_hi = {5'b0_0000, dsq_s2[48:36]};

	always_comb begin
		fo_c.d1   = d1_s2;
		fo_c.q    = q_c;
		fo_c.off  = $signed({4'b0000, coef.offset, 16'h0000})
			+ $signed({p4_adj[41], p4_adj[41:7]});
		fo_c.sens = $signed({5'b0_0000, coef.sens, 15'h0000})
			+ $signed({{2{p3_adj[41]}}, p3_adj[41:8]});
		fo_c.ti   = q_c[18] ? ti_lo : ti_hi;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			d1_s1 <= pressure_raw;
			dt_s1 <= $signed({1'b0, temperature_raw}) - $signed({1'b0, coef.ref_temp, 8'h00});
		end
		if (rdy_s2) begin
			d1_s2  <= d1_s1;
			p6_s2  <= dt_s1 * $signed({1'b0, coef.temp_slope});
			p4_s2  <= dt_s1 * $signed({1'b0, coef.offset_tempco});
			p3_s2  <= dt_s1 * $signed({1'b0, coef.sens_tempco});
			dsq_s2 <= dt_s1 * dt_s1;
		end
		if (rdy_s3) begin
			fo_s3 <= fo_c;
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = fo_s3;

	// high range Ti is dT^2/2^36, which stays below 2^13
	a_ti_high_small: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !fo_s3.q[18] |-> fo_s3.ti < 18'd8192)
		else $error("high range Ti out of bounds");

endmodule
`default_nettype wire

### rtl/psc_second_order.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_second_order
// range selection, corrected temperature, OFFi and SENSi terms (two stages)
// ----------------------------------------------------------------------------
module psc_second_order (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  psc_pkg::fo_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output psc_pkg::so_t   out_data
);
	import psc_pkg::*;

	logic vld_s4, vld_s5;
	logic rdy_s4, rdy_s5;

	logic [23:0]        d1_s4;
	logic signed [18:0] temp_s4;
	logic signed [35:0] off_s4, sens_s4;
	logic [35:0]        sq1_s4, sq2_s4;
	logic               lo_s4, vlo_s4;
	so_t                so_s5;

	logic signed [19:0] temp_c, dev2_c;
	logic signed [20:0] tfull_c;
	logic signed [18:0] tsat_c;
	logic signed [37:0] sq1_full;
	logic signed [39:0] sq2_full;

	logic [37:0] sq1x3;
	logic [38:0] sq1x5, sq2x7;
	logic [39:0] offi_c, sensi_c;

	assign rdy_s4   = ~vld_s4 | rdy_s5;
	assign rdy_s5   = ~vld_s5 | out_ready;
	assign in_ready = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s4) vld_s4 <= in_valid;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// temperature = 2000 + q - Ti, saturated to the output field
	assign temp_c  = $signed({in_data.q[18], in_data.q}) + TEMP_REF;
	assign tfull_c = $signed({temp_c[19], temp_c}) - $signed({3'b000, in_data.ti});
	assign tsat_c  = (tfull_c[20:18] == 3'b000 || tfull_c[20:18] == 3'b111)
		? tfull_c[18:0] : (tfull_c[20] ? TEMP_MIN : TEMP_MAX);

	assign dev2_c   = $signed({in_data.q[18], in_data.q}) + VLOW_BIAS;
	assign sq1_full = in_data.q * in_data.q;
	assign sq2_full = dev2_c * dev2_c;

	// shift-add forms of the 3/2, 5/8, 7x and 4x factors
	assign sq1x3 = {2'b00, sq1_s4} + {1'b0, sq1_s4, 1'b0};
	assign sq1x5 = {3'b000, sq1_s4} + {1'b0, sq1_s4, 2'b00};
	assign sq2x7 = {sq2_s4, 3'b000} - {3'b000, sq2_s4};

	always_comb begin
		if (lo_s4) begin
			offi_c  = {3'b000, sq1x3[37:1]} + (vlo_s4 ? {1'b0, sq2x7} : 40'd0);
			sensi_c = {4'h0, sq1x5[38:3]} + (vlo_s4 ? {2'b00, sq2_s4, 2'b00} : 40'd0);
		end else begin
			offi_c  = {8'h00, sq1_s4[35:4]};
			sensi_c = 40'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			d1_s4   <= in_data.d1;
			temp_s4 <= tsat_c;
			off_s4  <= in_data.off;
			sens_s4 <= in_data.sens;
			sq1_s4  <= sq1_full[35:0];
			sq2_s4  <= sq2_full[35:0];
			lo_s4   <= in_data.q[18];
			vlo_s4  <= in_data.q < VLOW_DEV;
		end
		if (rdy_s5) begin
			so_s5.d1   <= d1_s4;
			so_s5.temp <= temp_s4;
			so_s5.sd   <= $signed({{5{sens_s4[35]}}, sens_s4}) - $signed({1'b0, sensi_c});
			so_s5.od   <= $signed({{6{off_s4[35]}}, off_s4}) - $signed({2'b00, offi_c});
		end
	end

	assign out_valid = vld_s5;
	assign out_data  = so_s5;

	// the very low range is a part of the low range
	a_vlow_in_low: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && vlo_s4 |-> lo_s4)
		else $error("very low range flagged outside low range");

endmodule
`default_nettype wire

### rtl/psc_pressure.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pressure
// D1 scaling by split products, final offset and saturation (four stages)
// ----------------------------------------------------------------------------
module psc_pressure (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  psc_pkg::so_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [18:0]    temperature_centideg,
	output logic [31:0]    pressure_decimbar
);
	import psc_pkg::*;

	logic vld_s6, vld_s7, vld_s8, vld_s9;
	logic rdy_s6, rdy_s7, rdy_s8, rdy_s9;

	logic [44:0]        plo_s6;
	logic signed [44:0] phi_s6;
	logic               sneg_s6;
	logic signed [41:0] od_s6, od_s7;
	logic signed [18:0] temp_s6, temp_s7, temp_s8, temp_s9;
	logic signed [45:0] q21_s7;
	logic signed [46:0] diff_s8;
	logic signed [31:0] pres_s9;

	logic               fix_c;
	logic signed [46:0] adj_c;
	logic               sat_c;
	logic signed [31:0] pres_c;

	assign rdy_s6   = ~vld_s6 | rdy_s7;
	assign rdy_s7   = ~vld_s7 | rdy_s8;
	assign rdy_s8   = ~vld_s8 | rdy_s9;
	assign rdy_s9   = ~vld_s9 | out_ready;
	assign in_ready = rdy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (rdy_s6) vld_s6 <= in_valid;
			if (rdy_s7) vld_s7 <= vld_s6;
			if (rdy_s8) vld_s8 <= vld_s7;
			if (rdy_s9) vld_s9 <= vld_s8;
		end
	end

	// low 21 bits of the product come only from the low partial product;
	// a negative product with a nonzero remainder rounds up toward zero
	assign fix_c = sneg_s6 & (|plo_s6[20:0]);

	assign adj_c  = diff_s8 + (diff_s8[46] ? 47'sd8191 : 47'sd0);
	assign sat_c  = ~(adj_c[46:44] == 3'b000 || adj_c[46:44] == 3'b111);
	assign pres_c = sat_c ? (adj_c[46] ? PRES_MIN : PRES_MAX) : adj_c[44:13];

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			plo_s6  <= in_data.d1 * in_data.sd[20:0];
			phi_s6  <= $signed({1'b0, in_data.d1}) * $signed(in_data.sd[40:21]);
			sneg_s6 <= in_data.sd[40];
			od_s6   <= in_data.od;
			temp_s6 <= in_data.temp;
		end
		if (rdy_s7) begin
			q21_s7  <= $signed({phi_s6[44], phi_s6}) + $signed({22'h0, plo_s6[44:21]})
				+ $signed({45'h0, fix_c});
			od_s7   <= od_s6;
			temp_s7 <= temp_s6;
		end
		if (rdy_s8) begin
			diff_s8 <= $signed({q21_s7[45], q21_s7}) - $signed({{5{od_s7[41]}}, od_s7});
			temp_s8 <= temp_s7;
		end
		if (rdy_s9) begin
			pres_s9 <= pres_c;
			temp_s9 <= temp_s8;
		end
	end

	assign out_valid            = vld_s9;
	assign temperature_centideg = temp_s9;
	assign pressure_decimbar    = pres_s9;

	// a positive overflow lands as the top of the range
	a_pres_sat_hi: assert property (@(posedge clk) disable iff (!arst_n)
		rdy_s9 && vld_s8 && sat_c && !adj_c[46] |=> pres_s9 == PRES_MAX)
		else $error("pressure did not saturate high");

endmodule
`default_nettype wire

### rtl/pressure_sensor_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// second order barometric compensation of raw pressure and temperature codes
// ----------------------------------------------------------------------------
//
//  channel   direction  beat contents
//  s_axis    in         raw pressure D1, raw temperature D2
//  m_axis    out        temperature in 0.01 degC, pressure in 0.1 mbar
//  cfg       in         one 16 bit calibration coefficient per write
//
//  one beat per cycle sustained while m_axis is ready; the nine register stages
//  s1..s9 lie between an accepted input beat and its output beat (the 24 x 41 bit
//  pressure product is split into two partial products over two stages)
//  arst_n clears the stage valid bits and the coefficients; data is not reset
//  each stage holds its beat while the next one is full, so bubbles close up
//  and a stall loses or repeats nothing; s_axis_tready drops only when every
//  stage is full and m_axis is stalled
//
module pressure_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	// calibration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [23:0] pressure_raw, [47:24] temperature_raw
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata    // [18:0] temperature_centideg, [50:19] pressure_decimbar
);
	import psc_pkg::*;

	coef_t coef_q;

	logic fo_valid, fo_ready;
	fo_t  fo_data;
	logic so_valid, so_ready;
	so_t  so_data;

	logic [18:0] temperature_centideg;
	logic [31:0] pressure_decimbar;

	// calibration registers, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SENS:          coef_q.sens          <= cfg_data;
				CFG_OFFSET:        coef_q.offset        <= cfg_data;
				CFG_SENS_TEMPCO:   coef_q.sens_tempco   <= cfg_data;
				CFG_OFFSET_TEMPCO: coef_q.offset_tempco <= cfg_data;
				CFG_REF_TEMP:      coef_q.ref_temp      <= cfg_data;
				CFG_TEMP_SLOPE:    coef_q.temp_slope    <= cfg_data;
				default: ;
			endcase
		end
	end

	// s1..s3: dT, TEMP, OFF, SENS and Ti
	psc_first_order u_first (
		.clk             (clk),
		.arst_n          (arst_n),
		.coef            (coef_q),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.pressure_raw    (s_axis_tdata[23:0]),
		.temperature_raw (s_axis_tdata[47:24]),
		.out_valid       (fo_valid),
		.out_ready       (fo_ready),
		.out_data        (fo_data)
	);

	// s4..s5: range split, final temperature, OFFi and SENSi
	psc_second_order u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fo_valid),
		.in_ready  (fo_ready),
		.in_data   (fo_data),
		.out_valid (so_valid),
		.out_ready (so_ready),
		.out_data  (so_data)
	);

	// s6..s9: D1 scaling, offset, rounding and saturation; s9 is the output register
	psc_pressure u_pressure (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (so_valid),
		.in_ready             (so_ready),
		.in_data              (so_data),
		.out_valid            (m_axis_tvalid),
		.out_ready            (m_axis_tready),
		.temperature_centideg (temperature_centideg),
		.pressure_decimbar    (pressure_decimbar)
	);

	assign m_axis_tdata = {5'b0_0000, pressure_decimbar, temperature_centideg};

	// backpressure at the input only when the whole pipe is full and stalled
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready && so_valid && fo_valid)
		else $error("input stalled while the pipe has room");

endmodule
`default_nettype wire

### bench/pressure_sensor_compensation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_tb
// self-checking bench for the second order pressure/temperature compensation
//
// raw conversion pairs are queued by a stimulus process and driven on s_axis
// by a clocked driver; a clocked monitor predicts each accepted beat with a
// 64-bit integer model of the compensation and checks the m_axis beats in
// order. calibration sets change between idle phases, and both stream sides
// idle or stall at random, including a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_tb;
	import psc_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int PIPE_LATENCY  = 9;
	localparam int NUM_PHASES    = 8;
	localparam int PHASE_ITEMS   = 240;
	localparam int HOLD_CYCLES   = 80;
	localparam int TIMEOUT_NS    = 10_000_000;
	localparam logic [RAW_W-1:0] RAW_MAX = 24'hFFFFFF;

	// indexes beyond the register file, writes there must be dropped
	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;

	// a plausible factory calibration
	localparam coef_t TYPICAL_COEFS = '{sens: 16'd34982, offset: 16'd36352,
		sens_tempco: 16'd20328, offset_tempco: 16'd22354,
		ref_temp: 16'd26646, temp_slope: 16'd26146};

	typedef enum logic [1:0] {BAND_HIGH, BAND_LOW, BAND_VERY_LOW} temp_band_t;
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [RAW_W-1:0] pressure_raw;
		logic [RAW_W-1:0] temperature_raw;
	} raw_pair_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_centideg;
		logic signed [PRES_W-1:0] pres_decimbar;
		temp_band_t               band;
	} reading_t;

	// dut ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        s_valid = 1'b0;
	logic        s_ready;
	logic [47:0] s_data = '0;
	logic        m_valid;
	logic        m_ready = 1'b0;
	logic [55:0] m_data;

	// bench state
	coef_t       coefs = '0;           // calibration as the block should hold it
	raw_pair_t   pending_pairs[$];     // conversion pairs waiting for the driver
	reading_t    expected_readings[$]; // compensated readings still owed
	reading_t    head;
	logic        in_taken = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int          hold_requests = 0;
	int          hold_served = 0;
	int          hold_left = 0;
	int          items_in = 0;
	int          readings_out = 0;
	int          mismatches = 0;
	int          input_stalls = 0;
	int          settings_seen = 0;
	int          band_hits[3] = '{0, 0, 0};

	always #(CLK_HALF) clk = ~clk;

	pressure_sensor_compensation i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),   // [23:0] pressure_raw, [47:24] temperature_raw
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data)    // [18:0] temperature_centideg, [50:19] pressure_decimbar
	);

	// compensation in 64-bit signed arithmetic; division truncates toward zero
	function automatic reading_t predict_reading(input logic [RAW_W-1:0] d1_raw,
			input logic [RAW_W-1:0] d2_raw);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint dt, temp, off, sens, ti, offi, sensi, dev, dev2, t, p;
		reading_t r;
		d1 = d1_raw;
		d2 = d2_raw;
		c1 = coefs.sens;
		c2 = coefs.offset;
		c3 = coefs.sens_tempco;
		c4 = coefs.offset_tempco;
		c5 = coefs.ref_temp;
		c6 = coefs.temp_slope;

		// first order
		dt   = d2 - c5 * 256;
		temp = 2000 + dt * c6 / 8388608;
		off  = c2 * 65536 + c4 * dt / 128;
		sens = c1 * 32768 + c3 * dt / 256;

		// second order, by temperature band
		dev = temp - 2000;
		if (temp < TEMP_REF) begin
			r.band = BAND_LOW;
			ti     = 3 * dt * dt / 64'sd8589934592;
			offi   = 3 * dev * dev / 2;
			sensi  = 5 * dev * dev / 8;
			if (temp < -1500) begin
				r.band = BAND_VERY_LOW;
				dev2   = temp + 1500;
				offi   = offi + 7 * dev2 * dev2;
				sensi  = sensi + 4 * dev2 * dev2;
			end
		end else begin
			r.band = BAND_HIGH;
			ti     = 2 * dt * dt / 64'sd137438953472;
			offi   = dev * dev / 16;
			sensi  = 0;
		end

		t = temp - ti;
		if (t > TEMP_MAX)
			t = TEMP_MAX;
		else if (t < TEMP_MIN)
			t = TEMP_MIN;
		p = (d1 * (sens - sensi) / 2097152 - (off - offi)) / 8192;
		if (p > PRES_MAX)
			p = PRES_MAX;
		else if (p < PRES_MIN)
			p = PRES_MIN;

		r.temp_centideg = t[TEMP_W-1:0];
		r.pres_decimbar = p[PRES_W-1:0];
		return r;
	endfunction

	// driver: a new beat goes out once the current one was taken
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_valid <= 1'b0;
			s_data  <= '0;
		end else if (!s_valid || in_taken) begin
			if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_valid <= 1'b1;
				s_data  <= {pending_pairs[0].temperature_raw, pending_pairs[0].pressure_raw};
				void'(pending_pairs.pop_front());
			end else begin
				s_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_CYCLES;
			m_ready     <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_ready   <= 1'b0;
		end else begin
			m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// monitor: predict on input beats, check on output beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= s_valid && s_ready;
			if (s_valid && !s_ready)
				input_stalls++;
			if (s_valid && s_ready) begin
				head = predict_reading(s_data[23:0], s_data[47:24]);
				expected_readings.push_back(head);
				band_hits[head.band]++;
				items_in++;
			end
			if (m_valid === 1'b1 && m_ready) begin
				readings_out++;
				if (expected_readings.size() == 0) begin
					$display("%0t unexpected output beat: expected none, got %h", $time, m_data);
					mismatches++;
				end else begin
					head = expected_readings.pop_front();
					if (m_data[18:0] !== head.temp_centideg) begin
						$display("%0t temperature mismatch: expected %0d, got %0d",
							$time, head.temp_centideg, $signed(m_data[18:0]));
						mismatches++;
					end
					if (m_data[50:19] !== head.pres_decimbar) begin
						$display("%0t pressure mismatch: expected %0d, got %0d",
							$time, head.pres_decimbar, $signed(m_data[50:19]));
						mismatches++;
					end
				end
			end
		end
	end

	// one register write, mirrored into the bench copy
	task automatic write_coef(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		case (idx)
			CFG_SENS:          coefs.sens = val;
			CFG_OFFSET:        coefs.offset = val;
			CFG_SENS_TEMPCO:   coefs.sens_tempco = val;
			CFG_OFFSET_TEMPCO: coefs.offset_tempco = val;
			CFG_REF_TEMP:      coefs.ref_temp = val;
			CFG_TEMP_SLOPE:    coefs.temp_slope = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// full calibration set; ends on a rising edge so queueing stays race free
	task automatic apply_coefs(input coef_t c);
		write_coef(CFG_SENS, c.sens);
		write_coef(CFG_OFFSET, c.offset);
		write_coef(CFG_SENS_TEMPCO, c.sens_tempco);
		write_coef(CFG_OFFSET_TEMPCO, c.offset_tempco);
		write_coef(CFG_REF_TEMP, c.ref_temp);
		write_coef(CFG_TEMP_SLOPE, c.temp_slope);
		@(posedge clk);
		settings_seen++;
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 51; recv_stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 51; end
			default:       begin send_idle_pct = 35; recv_stall_pct = 35; end
		endcase
	endtask

	task automatic offer(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
		pending_pairs.push_back('{pressure_raw: d1, temperature_raw: d2});
	endtask

	// mostly temperatures around the calibration point at random spans,
	// some fully random codes and some field extremes
	task automatic queue_random_readings(input int n);
		int span;
		int v;
		logic [RAW_W-1:0] d1;
		logic [RAW_W-1:0] d2;
		for (int i = 0; i < n; i++) begin
			d1 = RAW_W'($urandom_range(0, RAW_MAX));
			case ($urandom_range(0, 9))
				7, 8: d2 = RAW_W'($urandom());
				9: begin
					d1 = $urandom_range(0, 1) ? RAW_MAX : '0;
					d2 = $urandom_range(0, 1) ? RAW_MAX : '0;
				end
				default: begin
					span = 1 << $urandom_range(6, 23);
					v = int'({8'd0, coefs.ref_temp, 8'd0}) + int'($urandom_range(0, 2 * span)) - span;
					if (v < 0)
						v = 0;
					else if (v > int'(RAW_MAX))
						v = int'(RAW_MAX);
					d2 = v[RAW_W-1:0];
				end
			endcase
			offer(d1, d2);
		end
	endtask

	// wait until every queued pair went out and every reading came back
	task automatic wait_drain();
		while (pending_pairs.size() != 0 || s_valid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	initial begin
		coef_t c;
		int start;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// uncalibrated block, straight out of reset
		offer('0, '0);
		offer(RAW_MAX, RAW_MAX);
		offer(RAW_MAX, '0);
		offer('0, RAW_MAX);
		wait_drain();

		// reference at 2^23 and slope 2^15: temp moves by dt/256, so band
		// edges sit on exact codes
		c = TYPICAL_COEFS;
		c.ref_temp   = 16'h8000;
		c.temp_slope = 16'h8000;
		apply_coefs(c);
		offer(24'd4500000, 24'd8388608);            // exactly 20.00 degC, high band
		offer(24'd4500000, 24'd8388608 - 24'd255);  // still 20.00 after truncation
		offer(24'd4500000, 24'd8388608 - 24'd256);  // 19.99, low band
		offer(24'd4500000, 24'd8388608 - 24'd896255); // -15.00 edge, not very low
		offer(24'd4500000, 24'd8388608 - 24'd896256); // -15.01, very low band
		offer(24'd4500000, 24'd12582912);           // hot
		offer(24'd4500000, '0);                     // coldest code
		offer(24'd4500000, RAW_MAX);                // hottest code
		offer('0, 24'd8388608 - 24'd896256);
		offer(RAW_MAX, 24'd8388608 - 24'd896256);
		wait_drain();

		// writes past the register file must change nothing
		write_coef(CFG_SPARE_LO, 16'hFFFF);
		write_coef(CFG_SPARE_HI, 16'hFFFF);
		@(posedge clk);
		offer(24'd4500000, 24'd8388608 - 24'd896256);
		wait_drain();

		// every coefficient at its maximum
		apply_coefs('1);
		offer('0, '0);
		offer(RAW_MAX, RAW_MAX);
		offer(RAW_MAX, '0);
		offer('0, RAW_MAX);
		wait_drain();

		// random phases, each with its own calibration and idling pattern
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: c = TYPICAL_COEFS;
				2: c = '0;
				4: c = '1;
				default: begin
					c.sens          = COEF_W'($urandom_range(0, 16'hFFFF));
					c.offset        = COEF_W'($urandom_range(0, 16'hFFFF));
					c.sens_tempco   = COEF_W'($urandom_range(0, 16'hFFFF));
					c.offset_tempco = COEF_W'($urandom_range(0, 16'hFFFF));
					c.ref_temp      = COEF_W'($urandom_range(0, 16'hFFFF));
					c.temp_slope    = COEF_W'($urandom_range(0, 16'hFFFF));
				end
			endcase
			apply_coefs(c);
			set_idling(idle_mode_t'(p % 4));
			if (p == 0) begin
				// sender keeps offering while the output is held off, so the
				// pipeline fills and back-pressures the input
				start = items_in;
				queue_random_readings(PHASE_ITEMS);
				while (items_in < start + 16)
					@(posedge clk);
				hold_requests++;
			end else if (p == 2) begin
				// sender pauses mid-phase until every reading is back
				queue_random_readings(PHASE_ITEMS / 2);
				wait_drain();
				queue_random_readings(PHASE_ITEMS - PHASE_ITEMS / 2);
			end else begin
				queue_random_readings(PHASE_ITEMS);
			end
			wait_drain();
		end

		$display("%0d conversion pairs in, %0d readings out, %0d calibration sets",
			items_in, readings_out, settings_seen);
		$display("bands high/low/very low: %0d/%0d/%0d, input back-pressure cycles: %0d",
			band_hits[BAND_HIGH], band_hits[BAND_LOW], band_hits[BAND_VERY_LOW], input_stalls);
		if (mismatches == 0)
			$display("pressure_sensor_compensation_tb OK");
		else
			$display("pressure_sensor_compensation_tb NOT OK");
		$finish;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#(TIMEOUT_NS);
		$display("%0t timeout with %0d readings outstanding", $time, expected_readings.size());
		$display("pressure_sensor_compensation_tb NOT OK");
		$finish;
	end

endmodule

### files.f
rtl/psc_pkg.sv
rtl/psc_first_order.sv
rtl/psc_second_order.sv
rtl/psc_pressure.sv
rtl/pressure_sensor_compensation.sv
bench/pressure_sensor_compensation_tb.sv
